@@ rtl/core/aosb_pkg.sv @@
// ----------------------------------------------------------------------------
// aosb_pkg - shared types and constants for the age ordered slot buffer
// Slot count, field widths, status codes, register indexes, sequencer states.
// ----------------------------------------------------------------------------
package aosb_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int AGE_W       = 5;
  localparam int AGE_MAX     = 31;
  localparam int VAL_W       = 32;
  localparam int SLOT_W      = 4;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int OUT_DATA_W  = ((VAL_W + SLOT_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAKE_COUNT   = 1'b1;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  typedef enum logic [1:0] {
    ST_PUT_OK       = 2'd0,
    ST_PUT_FULL     = 2'd1,
    ST_TAKEN        = 2'd2,
    ST_TAKE_REFUSED = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT_SCAN,
    S_TAKE_SCAN,
    S_TAKE_POP,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

endpackage

@@ rtl/core/aosb_scan_unit.sv @@
// ----------------------------------------------------------------------------
// aosb_scan_unit - shared age compare unit
// Walks one slot age per step, tracks the oldest slot seen and flags free slots.
// ----------------------------------------------------------------------------
module aosb_scan_unit
  import aosb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scan_ctrl_t       ctrl_i,
  input  logic [AGE_W-1:0] age_i,
  input  logic [IDX_W-1:0] idx_i,
  output logic             free_o,
  output logic [IDX_W-1:0] pos_o
);

  logic [AGE_W-1:0] best_q, best_d;
  logic [IDX_W-1:0] pos_q, pos_d;

  assign free_o = (age_i == '0);
  assign pos_o  = pos_q;

  always_comb begin
    best_d = best_q;
    pos_d  = pos_q;
    if (ctrl_i.clear) begin
      best_d = '0;
      pos_d  = '0;
    end else if (ctrl_i.step && (age_i >= best_q)) begin
      // later slot wins a tie
      best_d = age_i;
      pos_d  = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
      pos_q  <= '0;
    end else begin
      best_q <= best_d;
      pos_q  <= pos_d;
    end
  end

endmodule

@@ rtl/core/age_ordered_slot_buffer_top.sv @@
// ----------------------------------------------------------------------------
// age_ordered_slot_buffer_top - slot buffer with per-slot ages
// Puts land in the lowest free slot; takes remove the oldest items in turn.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_axis   | in        | tuser: req_type; tdata: item_value
//  m_axis   | out       | tuser: status; tdata: out_value, slot_index; tlast: last_of_run
//  cfg      | in        | write enable, register index, 5-bit data
//
// A put scans slots from the lowest upward, k of them, k being at most slots_in_use.
// A take handles take_count items; each item is one full age scan
// through the shared compare unit, a pop step and a result step. A refusal may be
// decided on acceptance. Reset clears all ages and
// occupancy and returns the registers to 16 slots and a take count of 1.
// A stalled result holds the sequencer; the last result of an item waits in
// the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module age_ordered_slot_buffer_top
  import aosb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [VAL_W-1:0]      s_axis_tdata,   // [31:0] item_value
  input  logic                  s_axis_tuser,   // [0] req_type
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [31:0] out_value, [35:32] slot_index
  output logic [1:0]            m_axis_tuser,   // [1:0] status
  output logic                  m_axis_tlast,   // last_of_run
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  state_e state_q, state_d;

  logic [CFG_W-1:0] slots_cfg_q, take_cfg_q;
  logic [AGE_W-1:0] age_q [SLOTS];
  logic [AGE_W-1:0] age_d [SLOTS];
  logic [VAL_W-1:0] val_mem [SLOTS];
  logic             val_we;
  logic [IDX_W-1:0] val_waddr;

  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [VAL_W-1:0] req_val_q, req_val_d;

  status_e          res_status_q, res_status_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;
  logic [IDX_W-1:0] res_slot_q, res_slot_d;
  logic             res_last_q, res_last_d;

  logic             m_valid_q, m_valid_d;
  status_e          m_status_q;
  logic [VAL_W-1:0] m_val_q;
  logic [IDX_W-1:0] m_slot_q;
  logic             m_last_q;
  logic             m_load;

  logic [CNT_W-1:0] n_eff;
  logic             take_bad;
  scan_ctrl_t       scan_ctrl;
  logic             scan_free;
  logic [IDX_W-1:0] scan_pos;

  // clamp slots_in_use into 1..SLOTS
  always_comb begin
    if (slots_cfg_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(slots_cfg_q) > SLOTS) begin
      n_eff = CNT_W'(SLOTS);
    end else begin
      n_eff = CNT_W'(slots_cfg_q);
    end
  end

  assign take_bad = (take_cfg_q == '0) || (int'(take_cfg_q) > int'(n_eff))
                 || (int'(take_cfg_q) > MAX_RESULTS) || (int'(take_cfg_q) > int'(occ_q));

  aosb_scan_unit u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (scan_ctrl),
    .age_i  (age_q[idx_q]),
    .idx_i  (idx_q),
    .free_o (scan_free),
    .pos_o  (scan_pos)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_load        = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    rem_d        = rem_q;
    idx_d        = idx_q;
    req_val_d    = req_val_q;
    res_status_d = res_status_q;
    res_val_d    = res_val_q;
    res_slot_d   = res_slot_q;
    res_last_d   = res_last_q;
    age_d        = age_q;
    val_we       = 1'b0;
    val_waddr    = idx_q;
    scan_ctrl    = '0;
    m_valid_d    = m_valid_q && !m_axis_tready;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          req_val_d       = s_axis_tdata;
          idx_d           = '0;
          scan_ctrl.clear = 1'b1;
          res_val_d       = '0;
          res_slot_d      = '0;
          res_last_d      = 1'b1;
          if (s_axis_tuser == REQ_PUT) begin
            if (occ_q < n_eff) begin
              state_d = S_PUT_SCAN;
            end else begin
              res_status_d = ST_PUT_FULL;
              state_d      = S_EMIT;
            end
          end else begin
            if (take_bad) begin
              res_status_d = ST_TAKE_REFUSED;
              state_d      = S_EMIT;
            end else begin
              rem_d   = CNT_W'(take_cfg_q);
              state_d = S_TAKE_SCAN;
            end
          end
        end
      end

      S_PUT_SCAN: begin
        if (scan_free) begin
          // age the occupied slots, then claim the free one
          for (int i = 0; i < SLOTS; i++) begin
            if (age_q[i] != '0 && int'(age_q[i]) < AGE_MAX) begin
              age_d[i] = age_q[i] + AGE_W'(1);
            end
          end
          age_d[idx_q] = AGE_W'(1);
          val_we       = 1'b1;
          val_waddr    = idx_q;
          occ_d        = occ_q + CNT_W'(1);
          res_status_d = ST_PUT_OK;
          res_val_d    = req_val_q;
          res_slot_d   = idx_q;
          state_d      = S_EMIT;
        end else if (int'(idx_q) + 1 >= int'(n_eff)) begin
          res_status_d = ST_PUT_FULL;
          state_d      = S_EMIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_TAKE_SCAN: begin
        scan_ctrl.step = 1'b1;
        if (idx_q == IDX_W'(SLOTS - 1)) begin
          state_d = S_TAKE_POP;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_TAKE_POP: begin
        age_d[scan_pos] = '0;
        occ_d           = occ_q - CNT_W'(1);
        rem_d           = rem_q - CNT_W'(1);
        res_status_d    = ST_TAKEN;
        res_val_d       = val_mem[scan_pos];
        res_slot_d      = scan_pos;
        res_last_d      = (rem_q == CNT_W'(1));
        state_d         = S_EMIT;
      end

      S_EMIT: begin
        if (m_load) begin
          m_valid_d = 1'b1;
          if (res_last_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d           = '0;
            scan_ctrl.clear = 1'b1;
            state_d         = S_TAKE_SCAN;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      slots_cfg_q <= CFG_W'(16);
      take_cfg_q  <= CFG_W'(1);
      occ_q       <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      m_valid_q   <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      rem_q     <= rem_d;
      idx_q     <= idx_d;
      m_valid_q <= m_valid_d;
      age_q     <= age_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_SLOTS_IN_USE: slots_cfg_q <= cfg_wdata_i;
          REG_TAKE_COUNT:   take_cfg_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    req_val_q    <= req_val_d;
    res_status_q <= res_status_d;
    res_val_q    <= res_val_d;
    res_slot_q   <= res_slot_d;
    res_last_q   <= res_last_d;
    if (val_we) begin
      val_mem[val_waddr] <= req_val_q;
    end
    if (state_q == S_EMIT && m_load) begin
      m_status_q <= res_status_q;
      m_val_q    <= res_val_q;
      m_slot_q   <= res_slot_q;
      m_last_q   <= res_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {(OUT_DATA_W - VAL_W - SLOT_W)'(0), SLOT_W'(m_slot_q), m_val_q};

endmodule
